[hdl/mdp_pkg.sv]
// Shared types, constants and the log2 lookup table for the dew point pipeline.
// Depends on nothing; every other file refers to it by scoped names.
package mdp_pkg;

  localparam int LOG_TABLE_BITS = 8;
  localparam int LOG_SIZE       = 1 << LOG_TABLE_BITS;
  localparam int LOG_ROM_N      = LOG_SIZE + 1;
  localparam int IDX_W          = LOG_TABLE_BITS + 1;
  localparam int LO_W           = 16 - LOG_TABLE_BITS;

  localparam logic [14:0] TN_POS    = 15'd24312;
  localparam logic [14:0] TN_NEG    = 15'd27262;
  localparam logic [20:0] M_POS_Q16 = 21'd1154744;
  localparam logic [20:0] M_NEG_Q16 = 21'd1471939;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [13:0] HUM_FULL  = 14'd10000;

  localparam logic [1:0] ST_VALID  = 2'd0;
  localparam logic [1:0] ST_NO_HUM = 2'd1;
  localparam logic [1:0] ST_CLAMP  = 2'd2;

  // Shared divider geometry: 38-bit dividend, 23-bit divisor, 23 quotient bits.
  localparam int DIV_N   = 23;
  localparam int NUM_W   = 38;
  localparam int DEN_W   = 23;

  typedef logic [16:0] rom_word_t;
  typedef rom_word_t rom_arr_t [LOG_ROM_N];

  typedef struct packed {
    logic               zero;
    logic               neg;
    logic [14:0]        tn;
    logic [20:0]        m;
    logic signed [20:0] lnv;
  } side_t;

  // log2(1 + i / 2^B) in Q16, found by repeated squaring in Q30.
  function automatic rom_word_t rom_entry(input int unsigned i);
    logic [63:0] y;
    logic [16:0] res;
    y = (64'(LOG_SIZE) + 64'(i)) << (30 - LOG_TABLE_BITS);
    res = '0;
    if (y >= (64'd2 << 30)) begin
      res = 17'd1;
      y = y >> 1;
    end
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 30;
      res = res << 1;
      if (y >= (64'd2 << 30)) begin
        res[0] = 1'b1;
        y = y >> 1;
      end
    end
    return res;
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t a;
    for (int i = 0; i < LOG_ROM_N; i++) a[i] = rom_entry(i);
    return a;
  endfunction

  localparam rom_arr_t LOG_ROM = build_rom();

  // Same interpolation as the datapath, evaluated on a constant.
  function automatic logic [20:0] log2_const(input logic [13:0] x);
    logic [3:0]  p;
    logic [29:0] nrm;
    logic [15:0] f;
    logic [IDX_W-1:0] idx;
    logic [16:0] e0;
    logic [16:0] e1;
    logic [16+LO_W:0] prd;
    p = '0;
    for (int i = 0; i < 14; i++) if (x[i]) p = 4'(i);
    nrm = {x, 16'b0} >> p;
    f = nrm[15:0];
    idx = IDX_W'(f[15:LO_W]);
    e0 = LOG_ROM[idx];
    e1 = LOG_ROM[idx + 1'b1];
    prd = (e1 - e0) * f[LO_W-1:0];
    return {1'b0, p, 16'b0} + 21'(e0) + 21'(prd >> LO_W);
  endfunction

  localparam logic [20:0] LOG2_FULL = log2_const(HUM_FULL);

endpackage

[hdl/mdp_log.sv]
// Front end: humidity clamp, table log2 with interpolation, ln scaling and
// the numerator and denominator of the first division. Uses mdp_pkg.
module mdp_log (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       i_valid,
  input  logic signed [14:0]         i_temperature,
  input  logic [13:0]                i_humidity,
  output logic                       o_valid,
  output logic [mdp_pkg::NUM_W-1:0]  o_num,
  output logic [mdp_pkg::DEN_W-1:0]  o_den,
  output mdp_pkg::side_t             o_side
);

  // Stage 1
  logic        a_valid_r;
  logic        a_zero_r, a_neg_r;
  logic [14:0] a_tabs_r, a_tn_r;
  logic [20:0] a_m_r;
  logic [3:0]  a_p_r;
  logic [15:0] a_f_r;
  // Stage 2
  logic        b_valid_r;
  logic        b_zero_r, b_neg_r;
  logic [14:0] b_tn_r;
  logic [20:0] b_m_r;
  logic [3:0]  b_p_r;
  logic [16:0] b_e0_r, b_diff_r;
  logic [mdp_pkg::LO_W-1:0] b_lo_r;
  logic [35:0] b_mt_r;
  logic [15:0] b_tnt_r;
  // Stage 3
  logic        c_valid_r;
  logic        c_zero_r, c_neg_r;
  logic [14:0] c_tn_r;
  logic [20:0] c_m_r;
  logic [20:0] c_mag_r;
  logic [35:0] c_mt_r;
  logic [15:0] c_tnt_r;
  // Stage 4
  logic        d_valid_r;
  logic        d_zero_r, d_neg_r;
  logic [14:0] d_tn_r;
  logic [20:0] d_m_r;
  logic [19:0] d_lnmag_r;
  logic [35:0] d_mt_r;
  logic [15:0] d_tnt_r;

  logic [13:0] h_cl;
  logic [3:0]  p_nxt;
  logic [29:0] nrm;
  logic [mdp_pkg::IDX_W-1:0] idx;
  logic [16:0] e0, e1;
  logic [16+mdp_pkg::LO_W:0] prd;
  logic [20:0] lg;
  logic [36:0] lnprod;

  always_comb begin
    h_cl = (i_humidity > mdp_pkg::HUM_FULL) ? mdp_pkg::HUM_FULL : i_humidity;
    p_nxt = '0;
    for (int i = 0; i < 14; i++) if (h_cl[i]) p_nxt = 4'(i);
    nrm = {h_cl, 16'b0} >> p_nxt;
  end

  always_comb begin
    idx = mdp_pkg::IDX_W'(a_f_r[15:mdp_pkg::LO_W]);
    e0  = mdp_pkg::LOG_ROM[idx];
    e1  = mdp_pkg::LOG_ROM[idx + 1'b1];
  end

  always_comb begin
    prd = b_diff_r * b_lo_r;
    lg  = {1'b0, b_p_r, 16'b0} + 21'(b_e0_r) + 21'(prd >> mdp_pkg::LO_W);
    lnprod = 37'(c_mag_r) * 37'(mdp_pkg::LN2_Q16) + 37'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= i_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_zero_r <= (h_cl == 14'd0);
      a_neg_r  <= i_temperature[14];
      a_tabs_r <= i_temperature[14] ? 15'(-i_temperature) : 15'(i_temperature);
      a_tn_r   <= i_temperature[14] ? mdp_pkg::TN_NEG : mdp_pkg::TN_POS;
      a_m_r    <= i_temperature[14] ? mdp_pkg::M_NEG_Q16 : mdp_pkg::M_POS_Q16;
      a_p_r    <= p_nxt;
      a_f_r    <= nrm[15:0];

      b_zero_r <= a_zero_r;
      b_neg_r  <= a_neg_r;
      b_tn_r   <= a_tn_r;
      b_m_r    <= a_m_r;
      b_p_r    <= a_p_r;
      b_e0_r   <= e0;
      b_diff_r <= e1 - e0;
      b_lo_r   <= a_f_r[mdp_pkg::LO_W-1:0];
      b_mt_r   <= 36'(a_m_r) * 36'(a_tabs_r);
      b_tnt_r  <= a_neg_r ? (16'(a_tn_r) - 16'(a_tabs_r)) : (16'(a_tn_r) + 16'(a_tabs_r));

      c_zero_r <= b_zero_r;
      c_neg_r  <= b_neg_r;
      c_tn_r   <= b_tn_r;
      c_m_r    <= b_m_r;
      c_mag_r  <= mdp_pkg::LOG2_FULL - lg;
      c_mt_r   <= b_mt_r;
      c_tnt_r  <= b_tnt_r;

      d_zero_r  <= c_zero_r;
      d_neg_r   <= c_neg_r;
      d_tn_r    <= c_tn_r;
      d_m_r     <= c_m_r;
      d_lnmag_r <= lnprod[35:16];
      d_mt_r    <= c_mt_r;
      d_tnt_r   <= c_tnt_r;
    end
  end

  assign o_valid     = d_valid_r;
  assign o_num       = mdp_pkg::NUM_W'(d_mt_r);
  assign o_den       = mdp_pkg::DEN_W'(d_tnt_r);
  assign o_side.zero = d_zero_r;
  assign o_side.neg  = d_neg_r;
  assign o_side.tn   = d_tn_r;
  assign o_side.m    = d_m_r;
  assign o_side.lnv  = -$signed({1'b0, d_lnmag_r});

endmodule

[hdl/mdp_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Unsigned operands; the quotient must fit in DIV_N bits. Uses mdp_pkg.
module mdp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       i_valid,
  input  logic [mdp_pkg::NUM_W-1:0]  i_num,
  input  logic [mdp_pkg::DEN_W-1:0]  i_den,
  input  mdp_pkg::side_t             i_side,
  output logic                       o_valid,
  output logic [mdp_pkg::DIV_N-1:0]  o_quo,
  output mdp_pkg::side_t             o_side
);

  localparam int N = mdp_pkg::DIV_N;
  localparam int DW = mdp_pkg::DEN_W;

  logic                     valid_r [N];
  logic [DW-1:0]            rem_r   [N];
  logic [N-1:0]             lowq_r  [N];
  logic [DW-1:0]            den_r   [N];
  mdp_pkg::side_t           side_r  [N];

  logic [DW-1:0]            rem_in  [N];
  logic [N-1:0]             lowq_in [N];
  logic [DW-1:0]            den_in  [N];
  logic [DW-1:0]            rem_nxt [N];
  logic [N-1:0]             lowq_nxt[N];

  // Each stage shifts the next dividend bit out of the top of lowq and the
  // new quotient bit into its bottom.
  always_comb begin
    for (int s = 0; s < N; s++) begin
      logic [DW:0] trial;
      logic        ge;
      if (s == 0) begin
        rem_in[s]  = DW'(i_num[mdp_pkg::NUM_W-1:N]);
        lowq_in[s] = i_num[N-1:0];
        den_in[s]  = i_den;
      end else begin
        rem_in[s]  = rem_r[s-1];
        lowq_in[s] = lowq_r[s-1];
        den_in[s]  = den_r[s-1];
      end
      trial = {rem_in[s], lowq_in[s][N-1]};
      ge    = (trial >= {1'b0, den_in[s]});
      rem_nxt[s]  = ge ? DW'(trial - {1'b0, den_in[s]}) : trial[DW-1:0];
      lowq_nxt[s] = {lowq_in[s][N-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < N; s++) valid_r[s] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= i_valid;
      for (int s = 1; s < N; s++) valid_r[s] <= valid_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < N; s++) begin
        rem_r[s]  <= rem_nxt[s];
        lowq_r[s] <= lowq_nxt[s];
        den_r[s]  <= den_in[s];
      end
      side_r[0] <= i_side;
      for (int s = 1; s < N; s++) side_r[s] <= side_r[s-1];
    end
  end

  assign o_valid = valid_r[N-1];
  assign o_quo   = lowq_r[N-1];
  assign o_side  = side_r[N-1];

endmodule

[hdl/magnus_dew_point.sv]
// Magnus-formula dew point from temperature and relative humidity.
// Uses mdp_pkg, mdp_log and two instances of mdp_div.
//
// Input channel: in_valid, in_stall, in_temperature (signed hundredths of a
// degree) and in_humidity (hundredths of a percent). A transfer happens at a
// rising edge with in_valid high and in_stall low.
// Result channel: out_valid, out_stall, out_dew_point (signed hundredths) and
// out_status (valid, humidity zero, clamped low).
// Throughput is one sample per cycle while out_stall does not hold the pipeline.
// From the input transfer to out_valid a sample passes four front-end stages
// for the table logarithm and ln scaling, 23 stages of the first divider
// (saturation ratio), two stages forming the second quotient's operands, 23
// stages of the second divider and the output register.
// The whole pipeline advances together; while a shown result is stalled,
// in_stall is raised and every stage holds, so nothing is lost or repeated.
// Bubbles inside the pipeline still move whenever the output is free.
// Reset (rst_n low, synchronous) clears all valid bits; the block keeps no
// other state, and samples are independent of each other.
module magnus_dew_point (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] in_temperature,
  input  logic [13:0]        in_humidity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_dew_point,
  output logic [1:0]         out_status
);

  logic en;

  logic                       f_valid;
  logic [mdp_pkg::NUM_W-1:0]  f_num;
  logic [mdp_pkg::DEN_W-1:0]  f_den;
  mdp_pkg::side_t             f_side;

  logic                       q1_valid;
  logic [mdp_pkg::DIV_N-1:0]  q1;
  mdp_pkg::side_t             q1_side;

  logic                       s_valid_r;
  logic signed [24:0]         s_r;
  mdp_pkg::side_t             s_side_r;

  logic                       n_valid_r;
  logic [mdp_pkg::NUM_W-1:0]  n_num_r;
  logic [mdp_pkg::DEN_W-1:0]  n_den_r;
  mdp_pkg::side_t             n_side_r;

  logic                       q2_valid;
  logic [mdp_pkg::DIV_N-1:0]  q2;
  mdp_pkg::side_t             q2_side;

  logic                       out_valid_r;
  logic signed [14:0]         dp_r;
  logic [1:0]                 st_r;
  logic signed [14:0]         dp_nxt;
  logic [1:0]                 st_nxt;

  logic signed [23:0]         r_sgn;
  logic signed [24:0]         s_nxt;
  logic [24:0]                s_abs;
  logic signed [25:0]         den2;
  logic signed [23:0]         dpv;
  mdp_pkg::side_t             n_side_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  mdp_log u_log (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .i_valid       (in_valid),
    .i_temperature (in_temperature),
    .i_humidity    (in_humidity),
    .o_valid       (f_valid),
    .o_num         (f_num),
    .o_den         (f_den),
    .o_side        (f_side)
  );

  mdp_div u_div_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (f_valid),
    .i_num   (f_num),
    .i_den   (f_den),
    .i_side  (f_side),
    .o_valid (q1_valid),
    .o_quo   (q1),
    .o_side  (q1_side)
  );

  always_comb begin
    r_sgn = q1_side.neg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    s_nxt = 25'(q1_side.lnv) + 25'(r_sgn);
    s_abs = s_r[24] ? 25'(-s_r) : 25'(s_r);
    den2  = $signed({5'b0, s_side_r.m}) - 26'(s_r);
    n_side_nxt     = s_side_r;
    n_side_nxt.neg = s_r[24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      n_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s_valid_r   <= q1_valid;
      n_valid_r   <= s_valid_r;
      out_valid_r <= q2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r      <= s_nxt;
      s_side_r <= q1_side;
      n_num_r  <= mdp_pkg::NUM_W'(s_side_r.tn) * mdp_pkg::NUM_W'(s_abs[22:0]);
      n_den_r  <= den2[mdp_pkg::DEN_W-1:0];
      n_side_r <= n_side_nxt;
      dp_r     <= dp_nxt;
      st_r     <= st_nxt;
    end
  end

  mdp_div u_div_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (n_valid_r),
    .i_num   (n_num_r),
    .i_den   (n_den_r),
    .i_side  (n_side_r),
    .o_valid (q2_valid),
    .o_quo   (q2),
    .o_side  (q2_side)
  );

  always_comb begin
    dpv = q2_side.neg ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
    priority if (q2_side.zero) begin
      dp_nxt = '0;
      st_nxt = mdp_pkg::ST_NO_HUM;
    end else if (dpv < -24'sd10000) begin
      dp_nxt = -15'sd10000;
      st_nxt = mdp_pkg::ST_CLAMP;
    end else if (dpv > 24'sd16383) begin
      dp_nxt = 15'sd16383;
      st_nxt = mdp_pkg::ST_VALID;
    end else begin
      dp_nxt = dpv[14:0];
      st_nxt = mdp_pkg::ST_VALID;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dew_point = dp_r;
  assign out_status    = st_r;

  a_no_hum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mdp_pkg::ST_NO_HUM |-> out_dew_point == 15'sd0)
    else $error("humidity-zero result carries a nonzero dew point");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mdp_pkg::ST_CLAMP |-> out_dew_point == -15'sd10000)
    else $error("clamped result is not at the lower limit");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_hold_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dew_point) && $stable(out_status))
    else $error("stalled result changed");

endmodule

[tb/sv/magnus_dew_point_tb.sv]
// Self-checking testbench for magnus_dew_point: random and directed samples with
// random idling on both sides, checked against a fixed-point dew point predictor.
// Depends on mdp_pkg for the status codes and on the magnus_dew_point RTL.
module magnus_dew_point_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_ITEMS   = 950;

  typedef struct {
    logic signed [14:0] dew_point;
    logic [1:0]         status;
  } dew_result_t;

  class dew_scoreboard;
    dew_result_t pending[$];
    int          errors;

    // log2(1 + i/256) in Q16, found by squaring in Q30.
    function automatic longint log_entry(int i);
      longint y;
      longint res;
      y = longint'(256 + i) << 22;
      res = 0;
      if (y >= (longint'(2) << 30)) begin
        res = 1;
        y = y >> 1;
      end
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        res = res << 1;
        if (y >= (longint'(2) << 30)) begin
          res = res | 1;
          y = y >> 1;
        end
      end
      return res;
    endfunction

    function automatic longint log2_fixed(int x);
      int     p;
      longint f;
      longint idx;
      longint lo;
      longint e0;
      longint e1;
      p = 0;
      while (p < 31 && (x >> (p + 1)) != 0) p++;
      f = (((longint'(x) << 16) >> p) - 65536) & 16'hFFFF;
      idx = f >> 8;
      lo = f & 8'hFF;
      e0 = log_entry(int'(idx));
      e1 = log_entry(int'(idx) + 1);
      return longint'(p) * 65536 + e0 + (((e1 - e0) * lo) >> 8);
    endfunction

    function automatic dew_result_t dew_point_of(logic signed [14:0] temp,
                                                 logic [13:0] hum);
      dew_result_t res;
      longint      t;
      longint      h;
      longint      tn;
      longint      m;
      longint      mag;
      longint      lnv;
      longint      r;
      longint      s;
      longint      dp;
      t = temp;
      h = hum;
      if (h > 10000) h = 10000;
      if (h == 0) begin
        res.dew_point = '0;
        res.status = mdp_pkg::ST_NO_HUM;
        return res;
      end
      tn = (t < 0) ? 27262 : 24312;
      m  = (t < 0) ? 1471939 : 1154744;
      mag = log2_fixed(10000) - log2_fixed(int'(h));
      lnv = -((mag * 45426 + 32768) >>> 16);
      r = (m * t) / (tn + t);
      s = lnv + r;
      dp = (tn * s) / (m - s);
      res.status = mdp_pkg::ST_VALID;
      if (dp < -10000) begin
        dp = -10000;
        res.status = mdp_pkg::ST_CLAMP;
      end else if (dp > 16383) begin
        dp = 16383;
      end
      res.dew_point = dp[14:0];
      return res;
    endfunction

    function void note_sample(logic signed [14:0] temp, logic [13:0] hum);
      pending.push_back(dew_point_of(temp, hum));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic signed [14:0] dp, logic [1:0] st);
      dew_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result dp=%0d status=%0d", dp, st));
        return;
      end
      want = pending.pop_front();
      if (dp !== want.dew_point)
        report($sformatf("dew_point %0d, expected %0d", dp, want.dew_point));
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [14:0] in_temperature;
  logic [13:0]        in_humidity;
  logic               out_valid;
  logic               out_stall;
  logic signed [14:0] out_dew_point;
  logic [1:0]         out_status;

  dew_scoreboard sb;
  int            results_seen;
  int            idle_cycles;
  bit            sending_done;

  magnus_dew_point dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_temperature(in_temperature), .in_humidity(in_humidity),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_dew_point(out_dew_point), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshakes are decided at the falling edge, where every signal is settled.
  always @(negedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_sample(in_temperature, in_humidity);
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_dew_point, out_status);
      results_seen++;
    end
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  task send_sample(logic signed [14:0] temp, logic [13:0] hum, int gap);
    bit taken;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_temperature <= temp;
    in_humidity <= hum;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic int pick_gap(int n);
    // Stretches of back-to-back transfers between the idling ones.
    return ((n / 100) % 3 == 1) ? 0 : $urandom_range(0, 4);
  endfunction

  task send_random(int n);
    logic signed [14:0] temp;
    logic [13:0]        hum;
    int                 kind;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      temp = 15'($urandom_range(0, 16380) - 4000);
      hum  = 14'($urandom_range(1, 10000));
    end else if (kind == 8) begin
      temp = 15'($urandom_range(0, 16380) - 4000);
      hum  = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'($urandom_range(10001, 16383));
    end else begin
      temp = 15'($urandom);
      hum  = 14'($urandom);
    end
    send_sample(temp, hum, pick_gap(n));
  endtask

  initial begin
    logic signed [14:0] temps [7] = '{-15'sd4000, 15'sd12380, 15'sd0, -15'sd1,
                                      -15'sd16384, 15'sd16383, 15'sd2000};
    logic [13:0]        hums [4]  = '{14'd1, 14'd10000, 14'd10001, 14'd16383};
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_temperature = '0;
    in_humidity = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Zero humidity, clamp above full scale, both coefficient sets and the
    // low clamp (cold and very dry) come from this grid.
    send_sample(-15'sd4000, 14'd0, 0);
    foreach (temps[i])
      foreach (hums[j]) send_sample(temps[i], hums[j], $urandom_range(0, 1));
    for (int n = 0; n < RANDOM_ITEMS; n++) send_random(n);
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // The receiver waits before each result (randomly, not at all when (seen / 100) % 4
  // is 2, or long at 150 and 600 results), then holds ready until it takes that result.
  initial begin
    int wait_n;
    int seen;
    out_stall = 1'b1;
    wait (rst_n);
    @(posedge clk);
    forever begin
      seen = results_seen;
      if (seen == 150 || seen == 600) begin
        // Long hold-off so the pipeline fills and backs up into the input.
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else if ((seen / 100) % 4 != 2) begin
        wait_n = $urandom_range(0, 4);
        if (wait_n > 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (results_seen == seen);
    end
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
